/* src/cfu_pkg.sv */
`timescale 1ns / 1ps

package cfu_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int COMP_W        = 32;
   localparam int MUL_W         = COMP_W + 1;
   localparam int PROD_W        = 2 * MUL_W;
   localparam int MUL_CNT_W     = $clog2(MUL_W);
   localparam int ROOT_STEPS    = 32;
   localparam int ROOT_CNT_W    = $clog2(ROOT_STEPS);
   localparam int DIV_W         = COMP_W + FRACTION_BITS + 1;
   localparam int DIV_CNT_W     = $clog2(DIV_W);
   localparam int WIDE_W        = PROD_W + 2;

   // request codes
   localparam logic [3:0] CMD_SLIDE_LEFT  = 4'd0;
   localparam logic [3:0] CMD_SLIDE_RIGHT = 4'd1;
   localparam logic [3:0] CMD_SLIDE_UP    = 4'd2;
   localparam logic [3:0] CMD_SLIDE_DOWN  = 4'd3;
   localparam logic [3:0] CMD_YAW_LEFT    = 4'd4;
   localparam logic [3:0] CMD_YAW_RIGHT   = 4'd5;
   localparam logic [3:0] CMD_PITCH_UP    = 4'd6;
   localparam logic [3:0] CMD_PITCH_DOWN  = 4'd7;
   localparam logic [3:0] CMD_ROLL_CW     = 4'd8;
   localparam logic [3:0] CMD_ROLL_CCW    = 4'd9;
   localparam logic [3:0] CMD_ZOOM        = 4'd10;

   // vector ids
   localparam logic [1:0] VEC_ORIGIN = 2'd0;
   localparam logic [1:0] VEC_FIRST  = 2'd1;
   localparam logic [1:0] VEC_SECOND = 2'd2;
   localparam logic [1:0] VEC_VIEW   = 2'd3;

   typedef struct packed {
      logic [3:0]         req_type;
      logic signed [31:0] step;
      logic [31:0]        zoom_factor;
   } cmd_req_type;

   typedef struct packed {
      logic [1:0]         vector_id;
      logic signed [31:0] comp_x;
      logic signed [31:0] comp_y;
      logic signed [31:0] comp_z;
      logic [30:0]        field_of_view;
      logic               zoom_changed;
      logic               last_vector;
   } cmd_rsp_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_SLIDE,
      KIND_TURN,
      KIND_ZOOM
   } cmd_kind_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ZOOM_MUL,
      ST_ZOOM_WAIT,
      ST_UPD_MA,
      ST_UPD_WA,
      ST_UPD_MB,
      ST_UPD_WB,
      ST_UPD_SH,
      ST_NRM_SQ,
      ST_NRM_SQW,
      ST_NRM_RT,
      ST_NRM_RTW,
      ST_NRM_DV,
      ST_NRM_DVW,
      ST_NRM_END,
      ST_WB,
      ST_EMIT
   } cfu_state_type;

   localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(64'sd2147483647);
   localparam logic signed [WIDE_W-1:0] SAT_LO = -WIDE_W'(64'sd2147483648);

   function automatic logic [31:0] sat_const(input logic [63:0] v);
      return (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
   endfunction

   function automatic logic [31:0] sat_wide(input logic signed [WIDE_W-1:0] v);
      logic [31:0] r;
      if (v > SAT_HI) begin
         r = 32'h7FFF_FFFF;
      end else if (v < SAT_LO) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   localparam logic [31:0] ONE_Q       = sat_const(64'd1 << FRACTION_BITS);
   localparam logic [31:0] ORIGIN_X_Q  = sat_const(64'd3 << (FRACTION_BITS - 1));
   localparam logic [31:0] ORIGIN_Y_Q  = sat_const(64'd2 << FRACTION_BITS);
   localparam logic [31:0] ANGLE_Q     = sat_const(64'd70 << FRACTION_BITS);

endpackage

/* src/camera_frame_updater.sv */
`timescale 1ns / 1ps

// Camera pose updater. Holds an origin, three unit axes (first, second,
// view) in signed Q16.16 and a vertical field of view in unsigned Q15.16,
// reset to origin (1.5, 2, 1), identity axes and 70 degrees. Each command
// transaction on req_ updates the pose and then yields four rsp_
// transactions, one per vector (origin, first, second, view) with the
// field of view and zoom flag alongside; last_vector marks the fourth. One
// command is in flight at a time and req_stall stays high from acceptance
// until the fourth result is loaded into the output register. Products,
// square roots and divides are bit-serial: a shift-add multiplier, a
// square root unit and a restoring divider set the pace. Zoom takes one
// product, a slide three, yaw/pitch/roll six and then, for each turned
// axis, three squares, one root and three divides; unused codes take
// none. Each is followed by four result transactions. A turned axis of
// zero length is left as it is.
module camera_frame_updater (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cfu_pkg::cmd_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cfu_pkg::cmd_rsp_type  rsp_data
);
   import cfu_pkg::*;

   // ---------------- state ----------------
   cfu_state_type      state_ff, state_in;

   logic signed [31:0] vec_ff [4][3];   // pose vectors by id, then x/y/z
   logic signed [31:0] wa_ff  [3];      // working vector a (rotates x->z)
   logic signed [31:0] wb_ff  [3];      // working vector b
   logic signed [MUL_W-1:0] k_ff;       // signed step, negated for some commands
   logic [1:0]         a_sel_ff;
   logic [1:0]         b_sel_ff;
   logic               is_turn_ff;
   logic [1:0]         cnt_ff;          // component counter
   logic               pass_ff;         // which axis is being normalized
   logic [63:0]        sum_ff;          // sum of squares
   logic [31:0]        n_ff;            // vector length
   logic signed [31:0] tmp_a_ff;
   logic signed [31:0] tmp_b_ff;
   logic [30:0]        angle_ff;
   logic               zflag_ff;
   logic [31:0]        factor_ff;
   logic [1:0]         out_id_ff;
   logic               rsp_valid_ff;
   cmd_rsp_type        rsp_data_ff;

   // ---------------- decode ----------------
   cmd_kind_type       dec_kind;
   logic [1:0]         dec_a_sel;
   logic [1:0]         dec_b_sel;
   logic               dec_neg;
   logic               accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      dec_kind  = KIND_NONE;
      dec_a_sel = VEC_ORIGIN;
      dec_b_sel = VEC_SECOND;
      dec_neg   = 1'b0;
      unique case (req_data.req_type) inside
         CMD_SLIDE_LEFT, CMD_SLIDE_RIGHT: begin
            dec_kind  = KIND_SLIDE;
            dec_a_sel = VEC_ORIGIN;
            dec_b_sel = VEC_SECOND;
            dec_neg   = (req_data.req_type == CMD_SLIDE_LEFT);
         end
         CMD_SLIDE_UP, CMD_SLIDE_DOWN: begin
            dec_kind  = KIND_SLIDE;
            dec_a_sel = VEC_ORIGIN;
            dec_b_sel = VEC_FIRST;
            dec_neg   = (req_data.req_type == CMD_SLIDE_DOWN);
         end
         CMD_YAW_LEFT, CMD_YAW_RIGHT: begin
            dec_kind  = KIND_TURN;
            dec_a_sel = VEC_VIEW;
            dec_b_sel = VEC_SECOND;
            dec_neg   = (req_data.req_type == CMD_YAW_RIGHT);
         end
         CMD_PITCH_UP, CMD_PITCH_DOWN: begin
            dec_kind  = KIND_TURN;
            dec_a_sel = VEC_FIRST;
            dec_b_sel = VEC_VIEW;
            dec_neg   = (req_data.req_type == CMD_PITCH_DOWN);
         end
         CMD_ROLL_CW, CMD_ROLL_CCW: begin
            dec_kind  = KIND_TURN;
            dec_a_sel = VEC_SECOND;
            dec_b_sel = VEC_FIRST;
            dec_neg   = (req_data.req_type == CMD_ROLL_CCW);
         end
         CMD_ZOOM: begin
            dec_kind = KIND_ZOOM;
         end
         default: begin
            dec_kind = KIND_NONE;
         end
      endcase
   end

   // ---------------- serial units ----------------
   logic                     mul_start;
   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic                     mul_done;
   logic signed [PROD_W-1:0] mul_prod;
   logic                     root_start;
   logic                     root_done;
   logic [31:0]              root_val;
   logic                     div_start;
   logic                     div_done;
   logic [DIV_W-1:0]         div_quo;
   logic [31:0]              wa_mag;

   assign wa_mag = wa_ff[0][31] ? (~wa_ff[0] + 1'b1) : wa_ff[0];

   cfu_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   cfu_root u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sum_ff),
      .done     (root_done),
      .root     (root_val)
   );

   cfu_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mag   (wa_mag),
      .den   (n_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // ---------------- result arithmetic ----------------
   localparam logic signed [PROD_W-1:0] SCALE_HALF = PROD_W'(1) <<< (FRACTION_BITS - 1);
   localparam logic [63:0]              ZOOM_HALF  = 64'd1 << (FRACTION_BITS - 1);

   logic signed [PROD_W-1:0] scaled;      // round_half_up(k*c / 2^F)
   logic signed [WIDE_W-1:0] scaled_w;
   logic signed [WIDE_W-1:0] wa0_w;
   logic signed [WIDE_W-1:0] wb0_w;
   logic [31:0]              upd_a;
   logic [31:0]              upd_b;
   logic [63:0]              zoom_rnd;
   logic [30:0]              zoom_angle;
   logic signed [WIDE_W-1:0] quo_w;
   logic [31:0]              norm_c;

   assign scaled   = (mul_prod + SCALE_HALF) >>> FRACTION_BITS;
   assign scaled_w = {{(WIDE_W - PROD_W){scaled[PROD_W-1]}}, scaled};
   assign wa0_w    = {{(WIDE_W - 32){wa_ff[0][31]}}, wa_ff[0]};
   assign wb0_w    = {{(WIDE_W - 32){wb_ff[0][31]}}, wb_ff[0]};
   // a turn subtracts from the first axis of the pair, a slide adds
   assign upd_a    = sat_wide(is_turn_ff ? (wa0_w - scaled_w) : (wa0_w + scaled_w));
   assign upd_b    = sat_wide(wb0_w + scaled_w);

   assign zoom_rnd   = (mul_prod[63:0] + ZOOM_HALF) >> FRACTION_BITS;
   assign zoom_angle = (zoom_rnd > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : zoom_rnd[30:0];

   assign quo_w  = {{(WIDE_W - DIV_W){1'b0}}, div_quo};
   assign norm_c = sat_wide(wa_ff[0][31] ? -quo_w : quo_w);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (dec_kind)
                  KIND_ZOOM:  state_in = ST_ZOOM_MUL;
                  KIND_SLIDE: state_in = ST_UPD_MA;
                  KIND_TURN:  state_in = ST_UPD_MA;
                  default:    state_in = ST_EMIT;
               endcase
            end
         end
         ST_ZOOM_MUL:  state_in = ST_ZOOM_WAIT;
         ST_ZOOM_WAIT: if (mul_done) state_in = ST_EMIT;
         ST_UPD_MA:    state_in = ST_UPD_WA;
         ST_UPD_WA: begin
            if (mul_done) state_in = is_turn_ff ? ST_UPD_MB : ST_UPD_SH;
         end
         ST_UPD_MB:    state_in = ST_UPD_WB;
         ST_UPD_WB:    if (mul_done) state_in = ST_UPD_SH;
         ST_UPD_SH: begin
            if (cnt_ff == 2'd2) begin
               state_in = is_turn_ff ? ST_NRM_SQ : ST_WB;
            end else begin
               state_in = ST_UPD_MA;
            end
         end
         ST_NRM_SQ:    state_in = ST_NRM_SQW;
         ST_NRM_SQW: begin
            if (mul_done) state_in = (cnt_ff == 2'd2) ? ST_NRM_RT : ST_NRM_SQ;
         end
         ST_NRM_RT:    state_in = ST_NRM_RTW;
         ST_NRM_RTW: begin
            if (root_done) state_in = (root_val == '0) ? ST_NRM_END : ST_NRM_DV;
         end
         ST_NRM_DV:    state_in = ST_NRM_DVW;
         ST_NRM_DVW: begin
            if (div_done) state_in = (cnt_ff == 2'd2) ? ST_NRM_END : ST_NRM_DV;
         end
         ST_NRM_END:   state_in = pass_ff ? ST_WB : ST_NRM_SQ;
         ST_WB:        state_in = ST_EMIT;
         ST_EMIT: begin
            if ((!rsp_valid_ff || !rsp_stall) && (out_id_ff == VEC_VIEW)) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // ---------------- control outputs ----------------
   logic out_load;

   always_comb begin
      mul_start  = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      root_start = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      req_stall  = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_ZOOM_MUL: begin
            mul_start = 1'b1;
            mul_a     = {2'b00, angle_ff};
            mul_b     = {1'b0, factor_ff};
         end
         ST_UPD_MA: begin
            mul_start = 1'b1;
            mul_a     = k_ff;
            mul_b     = {wb_ff[0][31], wb_ff[0]};
         end
         ST_UPD_MB: begin
            mul_start = 1'b1;
            mul_a     = k_ff;
            mul_b     = {wa_ff[0][31], wa_ff[0]};
         end
         ST_NRM_SQ: begin
            mul_start = 1'b1;
            mul_a     = {wa_ff[0][31], wa_ff[0]};
            mul_b     = {wa_ff[0][31], wa_ff[0]};
         end
         ST_NRM_RT: root_start = 1'b1;
         ST_NRM_DV: div_start  = 1'b1;
         ST_EMIT:   out_load   = !rsp_valid_ff || !rsp_stall;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- pose and control counters ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff[VEC_ORIGIN][0] <= ORIGIN_X_Q;
         vec_ff[VEC_ORIGIN][1] <= ORIGIN_Y_Q;
         vec_ff[VEC_ORIGIN][2] <= ONE_Q;
         vec_ff[VEC_FIRST][0]  <= ONE_Q;
         vec_ff[VEC_FIRST][1]  <= '0;
         vec_ff[VEC_FIRST][2]  <= '0;
         vec_ff[VEC_SECOND][0] <= '0;
         vec_ff[VEC_SECOND][1] <= ONE_Q;
         vec_ff[VEC_SECOND][2] <= '0;
         vec_ff[VEC_VIEW][0]   <= '0;
         vec_ff[VEC_VIEW][1]   <= '0;
         vec_ff[VEC_VIEW][2]   <= ONE_Q;
         angle_ff              <= ANGLE_Q[30:0];
         zflag_ff              <= 1'b1;
         cnt_ff                <= '0;
         pass_ff               <= 1'b0;
         out_id_ff             <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff    <= '0;
               pass_ff   <= 1'b0;
               out_id_ff <= '0;
            end
            ST_ZOOM_WAIT: begin
               if (mul_done) begin
                  angle_ff <= zoom_angle;
                  zflag_ff <= 1'b1;
               end
            end
            ST_UPD_SH: cnt_ff <= (cnt_ff == 2'd2) ? 2'd0 : cnt_ff + 1'b1;
            ST_NRM_SQW: begin
               if (mul_done) cnt_ff <= (cnt_ff == 2'd2) ? 2'd0 : cnt_ff + 1'b1;
            end
            ST_NRM_DVW: begin
               if (div_done) cnt_ff <= (cnt_ff == 2'd2) ? 2'd0 : cnt_ff + 1'b1;
            end
            ST_NRM_END: begin
               cnt_ff  <= '0;
               pass_ff <= ~pass_ff;
            end
            ST_WB: begin
               vec_ff[a_sel_ff] <= wa_ff;
               vec_ff[b_sel_ff] <= wb_ff;
            end
            ST_EMIT: if (out_load) out_id_ff <= out_id_ff + 1'b1;
            default: begin
            end
         endcase
      end
   end

   // ---------------- working datapath ----------------
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wa_ff      <= vec_ff[dec_a_sel];
               wb_ff      <= vec_ff[dec_b_sel];
               a_sel_ff   <= dec_a_sel;
               b_sel_ff   <= dec_b_sel;
               is_turn_ff <= (dec_kind == KIND_TURN);
               factor_ff  <= req_data.zoom_factor;
               k_ff       <= dec_neg ? -{req_data.step[31], req_data.step}
                                     :  {req_data.step[31], req_data.step};
            end
         end
         ST_UPD_WA: if (mul_done) tmp_a_ff <= upd_a;
         ST_UPD_WB: if (mul_done) tmp_b_ff <= upd_b;
         ST_UPD_SH: begin
            // both new values came from the old components; rotate now
            wa_ff[0] <= wa_ff[1];
            wa_ff[1] <= wa_ff[2];
            wa_ff[2] <= tmp_a_ff;
            wb_ff[0] <= wb_ff[1];
            wb_ff[1] <= wb_ff[2];
            wb_ff[2] <= is_turn_ff ? tmp_b_ff : wb_ff[0];
            if (cnt_ff == 2'd2) sum_ff <= '0;
         end
         ST_NRM_SQW: begin
            if (mul_done) begin
               sum_ff   <= sum_ff + mul_prod[63:0];
               wa_ff[0] <= wa_ff[1];
               wa_ff[1] <= wa_ff[2];
               wa_ff[2] <= wa_ff[0];
            end
         end
         ST_NRM_RTW: if (root_done) n_ff <= root_val;
         ST_NRM_DVW: begin
            if (div_done) begin
               wa_ff[0] <= wa_ff[1];
               wa_ff[1] <= wa_ff[2];
               wa_ff[2] <= norm_c;
            end
         end
         ST_NRM_END: begin
            // swap so the second axis goes through the same path
            wa_ff  <= wb_ff;
            wb_ff  <= wa_ff;
            sum_ff <= '0;
         end
         default: begin
         end
      endcase
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff.vector_id     <= out_id_ff;
         rsp_data_ff.comp_x        <= vec_ff[out_id_ff][0];
         rsp_data_ff.comp_y        <= vec_ff[out_id_ff][1];
         rsp_data_ff.comp_z        <= vec_ff[out_id_ff][2];
         rsp_data_ff.field_of_view <= angle_ff;
         rsp_data_ff.zoom_changed  <= zflag_ff;
         rsp_data_ff.last_vector   <= (out_id_ff == VEC_VIEW);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/cfu_mul.sv */
`timescale 1ns / 1ps

// Bit-serial signed multiplier, one multiplier bit per cycle.
module cfu_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [cfu_pkg::MUL_W-1:0]    op_a,
   input  logic signed [cfu_pkg::MUL_W-1:0]    op_b,
   output logic                                done,
   output logic signed [cfu_pkg::PROD_W-1:0]   prod
);
   import cfu_pkg::*;

   logic                    busy_ff;
   logic                    done_ff;
   logic [MUL_CNT_W-1:0]    cnt_ff;
   logic signed [MUL_W-1:0] a_ff;
   logic [MUL_W:0]          hi_ff;
   logic [MUL_W-1:0]        lo_ff;

   logic                    last;
   logic [MUL_W:0]          a_ext;
   logic [MUL_W:0]          addend;
   logic [MUL_W+1:0]        sum;

   assign last   = (cnt_ff == MUL_CNT_W'(MUL_W - 1));
   assign a_ext  = {a_ff[MUL_W-1], a_ff};
   // the top bit of the multiplier weighs negative
   assign addend = lo_ff[0] ? (last ? (~a_ext + 1'b1) : a_ext) : '0;
   assign sum    = {hi_ff[MUL_W], hi_ff} + {addend[MUL_W], addend};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= op_a;
         hi_ff <= '0;
         lo_ff <= op_b;
      end else if (busy_ff) begin
         hi_ff <= sum[MUL_W+1:1];
         lo_ff <= {sum[0], lo_ff[MUL_W-1:1]};
      end
   end

   assign done = done_ff;
   assign prod = PROD_W'({hi_ff, lo_ff});

endmodule

/* src/cfu_root.sv */
`timescale 1ns / 1ps

// Integer square root of a 64-bit value, one result bit per cycle.
module cfu_root (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   import cfu_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [ROOT_CNT_W-1:0] cnt_ff;
   logic [63:0]           n_ff;
   logic [63:0]           res_ff;
   logic [63:0]           bit_ff;

   logic                  last;
   logic [63:0]           trial;
   logic                  fits;

   assign last  = (cnt_ff == ROOT_CNT_W'(ROOT_STEPS - 1));
   assign trial = res_ff + bit_ff;
   assign fits  = (n_ff >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff   <= radicand;
         res_ff <= '0;
         bit_ff <= 64'd1 << 62;
      end else if (busy_ff) begin
         if (fits) begin
            n_ff   <= n_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

/* src/cfu_div.sv */
`timescale 1ns / 1ps

// Restoring divider for normalization: round(mag * 2^F / den),
// one quotient bit per cycle.
module cfu_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [31:0]                 mag,
   input  logic [31:0]                 den,
   output logic                        done,
   output logic [cfu_pkg::DIV_W-1:0]   quo
);
   import cfu_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]     num_ff;
   logic [31:0]          rem_ff;
   logic [31:0]          den_ff;

   logic                 last;
   logic [32:0]          trial;
   logic                 ge;
   logic [32:0]          diff;

   assign last  = (cnt_ff == DIV_CNT_W'(DIV_W - 1));
   assign trial = {rem_ff, num_ff[DIV_W-1]};
   assign ge    = (trial >= {1'b0, den_ff});
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         // numerator carries the half-divisor rounding term
         num_ff <= {1'b0, mag, {FRACTION_BITS{1'b0}}} + DIV_W'(den >> 1);
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[31:0] : trial[31:0];
         num_ff <= {num_ff[DIV_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quo  = num_ff;

endmodule

/* tb/sv/camera_frame_updater_tb.sv */
`timescale 1ns / 1ps

// Pose updater bench: commands go in as req_ transactions, four result
// transactions come back per command. A local pose model computes what
// each of them must carry.
module camera_frame_updater_tb;
   import cfu_pkg::*;

   localparam int F = FRACTION_BITS;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   cmd_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   cmd_rsp_type rsp_data;

   camera_frame_updater DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Pose model. Vectors are indexed origin, first, second, view so that
   // the vector id picks the row directly.
   // ---------------------------------------------------------------
   logic signed [31:0] pose [4][3];
   logic [31:0]        fov_q;
   logic               zoom_seen;

   cmd_rsp_type pending_vectors [$];
   int          fail_count = 0;
   int          rsp_count = 0;
   int          cmd_count = 0;

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // round half up of k*a / 2^F; arithmetic shift is floor division
   function automatic longint mul_q(input longint k, input logic signed [31:0] a);
      logic signed [127:0] q;
      q = 128'(k) * 128'(longint'(a)) + (128'sd1 <<< (F - 1));
      return longint'(q >>> F);
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      for (int i = 0; i < 32; i++) begin
         b = 64'd1 << (62 - 2 * i);
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   task automatic unit_scale(input int row);
      logic [63:0]  sum, n, mag;
      logic [127:0] quo;
      longint       c;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         c = pose[row][i];
         sum = sum + 64'(c * c);
      end
      n = isqrt64(sum);
      if (n == 0) return;      // zero length: left as it is
      for (int i = 0; i < 3; i++) begin
         c = pose[row][i];
         mag = (c < 0) ? 64'(-c) : 64'(c);
         quo = ((128'(mag) << F) + 128'(n >> 1)) / 128'(n);
         pose[row][i] = clamp32((c < 0) ? -longint'(quo) : longint'(quo));
      end
   endtask

   // p' = p - k*q, q' = q + k*p from old values, then both made unit
   task automatic rotate_pair(input int p, input int q, input longint k);
      logic signed [31:0] np [3];
      logic signed [31:0] nq [3];
      for (int i = 0; i < 3; i++) begin
         np[i] = clamp32(longint'(pose[p][i]) - mul_q(k, pose[q][i]));
         nq[i] = clamp32(longint'(pose[q][i]) + mul_q(k, pose[p][i]));
      end
      for (int i = 0; i < 3; i++) begin
         pose[p][i] = np[i];
         pose[q][i] = nq[i];
      end
      unit_scale(p);
      unit_scale(q);
   endtask

   task automatic move_origin(input int axis, input longint k);
      for (int i = 0; i < 3; i++)
         pose[0][i] = clamp32(longint'(pose[0][i]) + mul_q(k, pose[axis][i]));
   endtask

   task automatic pose_reset();
      pose = '{'{ORIGIN_X_Q, ORIGIN_Y_Q, ONE_Q}, '{ONE_Q, 0, 0},
               '{0, ONE_Q, 0}, '{0, 0, ONE_Q}};
      fov_q     = ANGLE_Q;
      zoom_seen = 1'b1;
   endtask

   // Apply one command to the model and queue its four vectors.
   task automatic predict_pose(input cmd_req_type c);
      longint      s;
      logic [63:0] zp;
      cmd_rsp_type r;
      s = longint'(c.step);
      case (c.req_type)
         CMD_SLIDE_LEFT:  move_origin(2, -s);
         CMD_SLIDE_RIGHT: move_origin(2, s);
         CMD_SLIDE_UP:    move_origin(1, s);
         CMD_SLIDE_DOWN:  move_origin(1, -s);
         CMD_YAW_LEFT:    rotate_pair(3, 2, s);
         CMD_YAW_RIGHT:   rotate_pair(3, 2, -s);
         CMD_PITCH_UP:    rotate_pair(1, 3, s);
         CMD_PITCH_DOWN:  rotate_pair(1, 3, -s);
         CMD_ROLL_CW:     rotate_pair(2, 1, s);
         CMD_ROLL_CCW:    rotate_pair(2, 1, -s);
         CMD_ZOOM: begin
            zp = (64'(fov_q) * 64'(c.zoom_factor) + (64'd1 << (F - 1))) >> F;
            fov_q = (zp > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : zp[31:0];
            zoom_seen = 1'b1;
         end
         default: ;
      endcase
      for (int k = 0; k < 4; k++) begin
         r.vector_id     = 2'(k);
         r.comp_x        = pose[k][0];
         r.comp_y        = pose[k][1];
         r.comp_z        = pose[k][2];
         r.field_of_view = fov_q[30:0];
         r.zoom_changed  = zoom_seen;
         r.last_vector   = (k == 3);
         pending_vectors.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------
   // Directed table. A typed-in row carries the full origin vector
   // expected right after it (only where it is obvious); the other rows
   // rely on the model alone.
   // ---------------------------------------------------------------
   typedef struct {
      cmd_req_type        cmd;
      bit                 has_origin;
      logic signed [31:0] ox, oy, oz;
   } dir_row_type;

   localparam logic signed [31:0] ONE = 32'sh0001_0000;

   dir_row_type dir_rows [$];

   task automatic add_row(input logic [3:0] op, input logic [31:0] st,
                          input logic [31:0] zf, input bit known = 0,
                          input logic [31:0] x = 0, input logic [31:0] y = 0,
                          input logic [31:0] z = 0);
      dir_row_type d;
      d.cmd = '{req_type: op, step: st, zoom_factor: zf};
      d.has_origin = known;
      d.ox = x; d.oy = y; d.oz = z;
      dir_rows.push_back(d);
   endtask

   cmd_req_type       cmd_feed [$];   // queue for commands; not filled by this bench
   logic signed [31:0] origin_check [$];
   bit                 origin_known [$];

   initial begin
      // unused code right after reset shows the reset pose
      add_row(4'd11, 32'h0, 32'h0, 1, ORIGIN_X_Q, ORIGIN_Y_Q, ONE);
      // slide right by one along the second axis: y gains one
      add_row(CMD_SLIDE_RIGHT, ONE, 32'h0, 1, ORIGIN_X_Q, ORIGIN_Y_Q + ONE, ONE);
      add_row(CMD_SLIDE_LEFT, ONE, 32'hFFFF_FFFF, 1, ORIGIN_X_Q, ORIGIN_Y_Q, ONE);
      add_row(CMD_SLIDE_UP, ONE, 32'h0, 1, ORIGIN_X_Q + ONE, ORIGIN_Y_Q, ONE);
      add_row(CMD_SLIDE_DOWN, ONE, 32'h0, 1, ORIGIN_X_Q, ORIGIN_Y_Q, ONE);
      // extremes of step, both signs, then back off
      add_row(CMD_SLIDE_UP, 32'h7FFF_FFFF, 32'h0);
      add_row(CMD_SLIDE_UP, 32'h8000_0000, 32'h0);
      add_row(CMD_SLIDE_DOWN, 32'h8000_0000, 32'h0);   // negated most-negative step
      add_row(CMD_SLIDE_LEFT, 32'h8000_0000, 32'h0);
      add_row(CMD_YAW_LEFT, 32'h0000_1000, 32'h0);
      add_row(CMD_YAW_RIGHT, 32'h0000_1000, 32'h0);
      add_row(CMD_PITCH_UP, 32'h0000_0800, 32'h0);
      add_row(CMD_PITCH_DOWN, 32'hFFFF_F000, 32'h0);
      add_row(CMD_ROLL_CW, 32'h0000_2000, 32'h0);
      add_row(CMD_ROLL_CCW, 32'h0000_2000, 32'h0);
      add_row(CMD_ROLL_CW, 32'h7FFF_FFFF, 32'h0);
      add_row(CMD_YAW_LEFT, 32'h8000_0000, 32'h0);
      add_row(CMD_PITCH_UP, 32'h0, 32'h0);
      add_row(CMD_ZOOM, 32'h0, 32'h0000_8000);        // halve
      add_row(CMD_ZOOM, 32'h0, 32'hFFFF_FFFF);        // saturate at the top
      add_row(CMD_ZOOM, 32'hFFFF_FFFF, 32'h0);        // down to zero
      add_row(CMD_ZOOM, 32'h0, 32'hFFFF_FFFF);        // zero stays zero
      add_row(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   end

   // ---------------------------------------------------------------
   // Sender: directed rows, then random commands. Small steps keep the
   // axes alive; a few big ones hit saturation.
   // ---------------------------------------------------------------
   int sent = 0;
   bit feed_done = 0;

   task automatic send_cmd(input cmd_req_type c);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(negedge clock);
      req_data  = c;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      predict_pose(c);
      cmd_count++;
      @(negedge clock);
      req_valid = 1'b0;
      req_data  = cmd_req_type'({$urandom, $urandom, $urandom});
   endtask

   function automatic cmd_req_type rand_cmd();
      cmd_req_type c;
      c.req_type    = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(11, 15))
                                                   : 4'($urandom_range(0, 10));
      case ($urandom_range(0, 9))
         0:       c.step = $urandom;                        // full range
         1:       c.step = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: c.step = 32'($signed(17'($urandom)) >>> 3);
      endcase
      case ($urandom_range(0, 5))
         0:       c.zoom_factor = $urandom;
         default: c.zoom_factor = $urandom_range(32'h0000_C000, 32'h0001_4000);
      endcase
      return c;
   endfunction

   initial begin
      int nrand;
      nrand = 87;
      @(negedge clock);
      wait (reset == 1'b0);
      @(negedge clock);
      foreach (dir_rows[i]) begin
         origin_known.push_back(dir_rows[i].has_origin);
         origin_check.push_back(dir_rows[i].ox);
         origin_check.push_back(dir_rows[i].oy);
         origin_check.push_back(dir_rows[i].oz);
         send_cmd(dir_rows[i].cmd);
      end
      // a pose with fresh reset-like axes is gone; let random take over
      for (int i = 0; i < nrand; i++) begin
         origin_known.push_back(0);
         origin_check.push_back(0); origin_check.push_back(0); origin_check.push_back(0);
         send_cmd(rand_cmd());
      end
      feed_done = 1;
   end

   // ---------------------------------------------------------------
   // Receiver: random stalls plus one long hold-off early on, while the
   // sender keeps offering, so the block fills and stalls its input.
   // ---------------------------------------------------------------
   initial begin
      int len;
      rsp_stall = 1'b0;
      wait (reset == 1'b0);
      repeat (30) @(negedge clock);
      rsp_stall = 1'b1;
      repeat (400) @(negedge clock);
      rsp_stall = 1'b0;
      forever begin
         len = $urandom_range(0, 40);
         repeat (len) @(negedge clock);
         rsp_stall = ($urandom_range(0, 2) == 0);
         if (rsp_stall)
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                                : $urandom_range(1, 4))
               @(negedge clock);
         rsp_stall = 1'b0;
      end
   end

   // result check, sampled at the rising edge
   always @(posedge clock) begin
      cmd_rsp_type e;
      int cmd_idx;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_vectors.size() == 0) begin
            $display("%0t: unexpected result transaction %p", $time, rsp_data);
            fail_count++;
         end else begin
            e = pending_vectors.pop_front();
            if (rsp_data !== e) begin
               $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
               fail_count++;
            end
            // typed-in origin of the directed rows, cross-check of the model
            cmd_idx = rsp_count / 4;
            if (e.vector_id == VEC_ORIGIN && cmd_idx < origin_known.size()
                && origin_known[cmd_idx]
                && {rsp_data.comp_x, rsp_data.comp_y, rsp_data.comp_z} !==
                   {origin_check[3*cmd_idx], origin_check[3*cmd_idx+1],
                    origin_check[3*cmd_idx+2]}) begin
               $display("%0t: origin expected %h %h %h actual %h %h %h", $time,
                        origin_check[3*cmd_idx], origin_check[3*cmd_idx+1],
                        origin_check[3*cmd_idx+2], rsp_data.comp_x,
                        rsp_data.comp_y, rsp_data.comp_z);
               fail_count++;
            end
         end
         rsp_count++;
      end
   end

   // reset, then wait for the end of traffic and drain
   initial begin
      pose_reset();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (feed_done);
      while (pending_vectors.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      $display("%0d commands sent, %0d vector results checked", cmd_count, rsp_count);
      $display("covered slides, turns, zoom with saturation, unused codes, long output stall");
      if (fail_count == 0 && pending_vectors.size() == 0) begin
         $display("camera_frame_updater_tb passed");
      end else begin
         $display("camera_frame_updater_tb failed");
      end
      $finish;
   end

   // ~110 cmds at their worst case plus stalls, taken many times over
   initial begin
      #20_000_000;
      $display("camera_frame_updater_tb failed");
      $finish;
   end

endmodule

/* sim.f */
src/cfu_pkg.sv
src/cfu_mul.sv
src/cfu_root.sv
src/cfu_div.sv
src/camera_frame_updater.sv
tb/sv/camera_frame_updater_tb.sv
